// File: design/b32e_pkg.sv
// Package for the base32 byte stream encoder.
// Holds the word and job types, the default queue depth and the symbol alphabet function.
// No dependencies.
`timescale 1ns / 1ps

package b32e_pkg;

  localparam int unsigned SymBits      = 5;
  localparam int unsigned ByteBits     = 8;
  localparam int unsigned MaxSyms      = 3;
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [6:0] AsciiA     = 7'd65;
  localparam logic [6:0] AsciiTwo   = 7'd50;
  localparam logic [4:0] LetterCount = 5'd26;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [6:0] symbol_char;
    logic       last_symbol;
  } out_word_t;

  typedef struct packed {
    logic [MaxSyms-1:0][SymBits-1:0] sym;
    logic [1:0]                      cnt;
    logic                            last;
  } job_t;

  function automatic logic [6:0] sym_ascii(input logic [4:0] v);
    logic [6:0] r;
    if (v < LetterCount) begin
      r = AsciiA + {2'b00, v};
    end else begin
      r = AsciiTwo + {2'b00, v - LetterCount};
    end
    return r;
  endfunction

endpackage

// File: design/base32_byte_stream_encoder.sv
// Top level of the base32 byte stream encoder.
// Instantiates the front end, the job queue and the back end.
// Depends on b32e_pkg, b32e_front, b32e_queue and b32e_back.
`timescale 1ns / 1ps

// Bytes enter most significant bit first and leave as unpadded RFC 4648 base32
// ASCII symbols, one symbol per word, with last_symbol set on the final symbol of
// each message. A byte is taken in every cycle while the job queue has room, and
// the back end sends one symbol per cycle while a job waits and output is popped,
// so a byte costs one to three symbols of output and about 1.6 on average. The first
// symbol of a byte passes the job queue and then the output register to the output.
module base32_byte_stream_encoder #(
  parameter int unsigned QUEUE_DEPTH = b32e_pkg::QueueDepthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  b32e_pkg::in_word_t  in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output b32e_pkg::out_word_t out_data
);

  logic           q_push, q_full, q_pop, q_empty;
  b32e_pkg::job_t q_wdata, q_rdata;

  b32e_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  b32e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  b32e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// File: design/b32e_front.sv
// Front end of the base32 encoder: accepts bytes and splits them into 5-bit groups.
// Keeps the leftover bits between bytes and emits one job per byte.
// Depends on b32e_pkg.
`timescale 1ns / 1ps

module b32e_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  b32e_pkg::in_word_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output b32e_pkg::job_t    q_data
);

  logic [3:0]  left_bits_r, left_bits_nxt;
  logic [2:0]  left_cnt_r, left_cnt_nxt;
  logic [11:0] acc;
  logic [3:0]  total;
  logic        two_full;
  logic [3:0]  sh0, sh1, rem4;
  logic [11:0] shr0, shr1;
  logic [2:0]  rem;
  logic [3:0]  mask4, low4;
  logic [4:0]  fill;
  logic        has_fill;

  always_comb begin
    acc      = {left_bits_r, in_data.data_byte};
    total    = {1'b0, left_cnt_r} + 4'd8;
    two_full = (total >= 4'd10);
    sh0      = total - 4'd5;
    sh1      = two_full ? (total - 4'd10) : 4'd0;
    shr0     = acc >> sh0;
    shr1     = acc >> sh1;
    rem4     = two_full ? (total - 4'd10) : (total - 4'd5);
    rem      = rem4[2:0];
    mask4    = 4'((5'd1 << rem) - 5'd1);
    low4     = acc[3:0] & mask4;
    fill     = 5'({1'b0, low4} << (3'd5 - rem));
    has_fill = in_data.last_byte && (rem != 3'd0);

    q_data.sym[0] = shr0[4:0];
    q_data.sym[1] = shr1[4:0];
    q_data.sym[2] = two_full ? fill : 5'd0;
    if (!two_full) begin
      q_data.sym[1] = fill;
    end
    q_data.cnt  = (two_full ? 2'd2 : 2'd1) + {1'b0, has_fill};
    q_data.last = in_data.last_byte;

    in_full = q_full;
    q_push  = in_push && !q_full;

    if (in_data.last_byte) begin
      left_bits_nxt = 4'd0;
      left_cnt_nxt  = 3'd0;
    end else begin
      left_bits_nxt = low4;
      left_cnt_nxt  = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_bits_r <= 4'd0;
      left_cnt_r  <= 3'd0;
    end else if (q_push) begin
      left_bits_r <= left_bits_nxt;
      left_cnt_r  <= left_cnt_nxt;
    end
  end

endmodule

// File: design/b32e_queue.sv
// Short job queue between the front and back ends of the base32 encoder.
// Register array with read and write pointers and an occupancy count.
// Depends on b32e_pkg.
`timescale 1ns / 1ps

module b32e_queue #(
  parameter int unsigned DEPTH = b32e_pkg::QueueDepthDef
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b32e_pkg::job_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output b32e_pkg::job_t rdata
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  b32e_pkg::job_t mem [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  always_comb begin
    full    = (count_r == CntW'(DEPTH));
    empty   = (count_r == '0);
    do_push = push && !full;
    do_pop  = pop && !empty;
    rdata   = mem[rd_ptr_r];

    wr_ptr_nxt = wr_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    rd_ptr_nxt = rd_ptr_r;
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: design/b32e_back.sv
// Back end of the base32 encoder: steps through the symbols of each job.
// Maps each 5-bit group to ASCII and holds it in the output register.
// Depends on b32e_pkg.
`timescale 1ns / 1ps

module b32e_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  b32e_pkg::job_t     q_data,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output b32e_pkg::out_word_t out_data
);

  logic                out_valid_r, out_valid_nxt;
  b32e_pkg::out_word_t out_data_r;
  logic [1:0]          idx_r, idx_nxt;
  logic                load, final_sym;

  always_comb begin
    load      = !q_empty && (!out_valid_r || out_pop);
    final_sym = (idx_r == q_data.cnt - 2'd1);
    q_pop     = load && final_sym;

    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = final_sym ? 2'd0 : idx_r + 2'd1;
    end

    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end

    out_empty = !out_valid_r;
    out_data  = out_data_r;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.symbol_char <= b32e_pkg::sym_ascii(q_data.sym[idx_r]);
      out_data_r.last_symbol <= q_data.last && final_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

endmodule

// File: sim/tb.sv
// Self-checking testbench for the base32 byte stream encoder.
// Drives a directed table and random messages with random idling on both sides.
// Depends on b32e_pkg and base32_byte_stream_encoder.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomBytes = 385;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned MaxPrinted  = 40;
  localparam logic [6:0]  CharA       = 7'd65;
  localparam logic [6:0]  CharTwo     = 7'd50;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [1:0]  n_typed;
    logic [23:0] chars;
  } stim_row_t;

  localparam int unsigned DirectedCount = 25;
  localparam stim_row_t DirectedRows [0:DirectedCount-1] = '{
    '{8'h00, 1'b1, 2'd2, "AA"},
    '{8'hFF, 1'b1, 2'd2, "74"},
    '{8'h66, 1'b1, 2'd2, "MY"},
    '{8'h66, 1'b0, 2'd1, "M"},
    '{8'h6F, 1'b0, 2'd2, "ZX"},
    '{8'h6F, 1'b0, 2'd1, "W"},
    '{8'h62, 1'b0, 2'd2, "6Y"},
    '{8'h61, 1'b1, 2'd2, "TB"},
    '{8'h66, 1'b0, 2'd1, "M"},
    '{8'h6F, 1'b1, 2'd3, "ZXQ"},
    '{8'h66, 1'b0, 2'd1, "M"},
    '{8'h6F, 1'b0, 2'd2, "ZX"},
    '{8'h6F, 1'b0, 2'd1, "W"},
    '{8'h62, 1'b1, 2'd3, "6YQ"},
    '{8'h80, 1'b1, 2'd0, 24'h0},
    '{8'hFF, 1'b0, 2'd0, 24'h0},
    '{8'hFF, 1'b0, 2'd0, 24'h0},
    '{8'hFF, 1'b0, 2'd0, 24'h0},
    '{8'hFF, 1'b0, 2'd0, 24'h0},
    '{8'hFF, 1'b1, 2'd0, 24'h0},
    '{8'h00, 1'b0, 2'd0, 24'h0},
    '{8'h00, 1'b0, 2'd0, 24'h0},
    '{8'h00, 1'b1, 2'd0, 24'h0},
    '{8'h55, 1'b0, 2'd0, 24'h0},
    '{8'hAA, 1'b1, 2'd0, 24'h0}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  logic                in_full;
  b32e_pkg::in_word_t  in_data = '0;
  logic                out_empty;
  logic                out_pop = 1'b0;
  b32e_pkg::out_word_t out_data;

  b32e_pkg::out_word_t symbol_q [$];
  logic [3:0]  pend_bits = '0;
  int unsigned pend_cnt = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned messages_sent = 0;
  int unsigned symbols_seen = 0;
  bit          burst_mode = 1'b0;

  base32_byte_stream_encoder u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  function automatic logic [6:0] to_symbol(input logic [4:0] v);
    if (v < 5'd26) begin
      return CharA + {2'b00, v};
    end
    return CharTwo + {2'b00, v - 5'd26};
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= MaxPrinted) begin
      $display("tb: mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got,
               want);
    end
  endtask

  // Advances the encoder state and returns the symbols that one byte yields.
  task automatic predict_symbols(input b32e_pkg::in_word_t w,
                                 output b32e_pkg::out_word_t syms [3],
                                 output int unsigned n);
    logic [11:0] acc;
    int unsigned total;
    acc = {pend_bits, w.data_byte};
    total = pend_cnt + 8;
    n = 0;
    while (total >= 5) begin
      total -= 5;
      syms[n] = '{symbol_char: to_symbol(5'(acc >> total)), last_symbol: 1'b0};
      n++;
    end
    acc &= (12'd1 << total) - 12'd1;
    if (w.last_byte) begin
      if (total > 0) begin
        syms[n] = '{symbol_char: to_symbol(5'(acc << (5 - total))), last_symbol: 1'b1};
        n++;
      end else begin
        syms[n-1].last_symbol = 1'b1;
      end
      pend_bits = '0;
      pend_cnt = 0;
    end else begin
      pend_bits = acc[3:0];
      pend_cnt = total;
    end
  endtask

  task automatic push_byte(input b32e_pkg::in_word_t w, input logic [1:0] n_typed,
                           input logic [23:0] chars);
    int unsigned         gap;
    int unsigned         n;
    b32e_pkg::out_word_t syms [3];
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_push <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_full);
    predict_symbols(w, syms, n);
    if (n_typed != 0) begin
      n = n_typed;
      for (int i = 0; i < n; i++) begin
        syms[i].symbol_char = chars[8 * (n - 1 - i) +: 7];
        syms[i].last_symbol = w.last_byte && (i == n - 1);
      end
    end
    for (int i = 0; i < n; i++) begin
      symbol_q.push_back(syms[i]);
    end
    bytes_sent++;
    if (w.last_byte) begin
      messages_sent++;
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: timeout after %0d cycles with %0d words pending", cycles,
               symbol_q.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      symbols_seen++;
      if (symbol_q.size() == 0) begin
        report_mismatch("unexpected word, symbol_char", out_data.symbol_char, -1);
      end else begin
        b32e_pkg::out_word_t want;
        want = symbol_q.pop_front();
        if (out_data.symbol_char !== want.symbol_char) begin
          report_mismatch("symbol_char", out_data.symbol_char, want.symbol_char);
        end
        if (out_data.last_symbol !== want.last_symbol) begin
          report_mismatch("last_symbol", out_data.last_symbol, want.last_symbol);
        end
      end
    end
  end

  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_pop <= 1'b0;
        stall--;
      end else begin
        out_pop <= 1'b1;
        if (!burst_mode && $urandom_range(0, 99) < 35) begin
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        end
      end
    end
  end

  initial begin
    int unsigned        count;
    int unsigned        len;
    b32e_pkg::in_word_t w;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < DirectedCount; i++) begin
      w = '{data_byte: DirectedRows[i].data, last_byte: DirectedRows[i].last};
      push_byte(w, DirectedRows[i].n_typed, DirectedRows[i].chars);
    end
    count = 0;
    while (count < RandomBytes) begin
      if ($urandom_range(0, 5) == 0) begin
        burst_mode = ~burst_mode;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      if (count + len > RandomBytes) begin
        len = RandomBytes - count;
      end
      for (int k = 0; k < len; k++) begin
        w.data_byte = 8'($urandom());
        w.last_byte = (k == len - 1);
        push_byte(w, 2'd0, 24'h0);
      end
      count += len;
    end
    @(negedge clk);
    in_push <= 1'b0;
    burst_mode = 1'b0;
    while (symbol_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("tb: %0d bytes in %0d messages sent, %0d symbols checked, %0d mismatches",
             bytes_sent, messages_sent, symbols_seen, errors);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
design/b32e_pkg.sv
design/b32e_front.sv
design/b32e_queue.sv
design/b32e_back.sv
design/base32_byte_stream_encoder.sv
sim/tb.sv
